>>> src/isrt_pkg.sv
// Shared types and constants for the insertion sorter.
// Used by the controller, the datapath and the top level.
`default_nettype none

package isrt_pkg;

  localparam int unsigned DATA_W = 32;

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture the incoming value and last flag
    logic place_direct;  // store empty: write incoming value at slot 0
    logic start_search;  // pos := fill, read slot fill-1
    logic shift;         // move read entry up one slot, step pos down
    logic place;         // write held value at pos, bump fill
    logic drop;          // store full: set the overflow flag
    logic emit_rd;       // read slot k for output, step k
    logic clear;         // end of run: clear fill, overflow and k
  } isrt_cmd_t;

  // Status back from the datapath.
  typedef struct packed {
    logic full;
    logic fill_zero;
    logic greater;   // read entry is strictly greater than held value
    logic pos_one;   // insertion point would be slot 0 after this shift
    logic k_last;    // output index is on the final stored entry
    logic last;      // held last flag
  } isrt_stat_t;

endpackage

`default_nettype wire

>>> src/isrt_datapath.sv
// Datapath of the insertion sorter: sorted store memory, counters and
// output registers. Driven by isrt_ctrl through isrt_pkg command types.
`default_nettype none

module isrt_datapath import isrt_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire isrt_cmd_t                cmd_i,
  output isrt_stat_t                    stat_o,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     last_i,
  output logic signed [DATA_W-1:0]      value_res_o,
  output logic                          last_res_o,
  output logic                          overflow_o,
  output logic                          res_strobe_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic [DATA_W-1:0] mem_q [MAX_ITEMS];
  logic [DATA_W-1:0] rdata_q;

  logic signed [DATA_W-1:0] value_q;
  logic                     last_q;
  logic [CW-1:0]            fill_q, fill_d;
  logic                     dropped_q, dropped_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic [AW-1:0]            k_q, k_d;
  logic                     out_v_q, out_last_q, out_ovf_q;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     fill_idx;

  assign fill_idx = fill_q[AW-1:0];

  // Write port: direct insert, shift up, or final placement.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = value_q;
    if (cmd_i.place_direct) begin
      wr_en   = 1'b1;
      wr_addr = fill_idx;
      wr_data = value_i;
    end else if (cmd_i.shift) begin
      wr_en   = 1'b1;
      wr_data = rdata_q;
    end else if (cmd_i.place) begin
      wr_en   = 1'b1;
    end
  end

  // Read port: neighbor below the insertion point, or output index.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k_q;
    if (cmd_i.start_search) begin
      rd_en   = 1'b1;
      rd_addr = fill_idx - AW'(1);
    end else if (cmd_i.shift) begin
      rd_en   = 1'b1;
      rd_addr = pos_q - AW'(2);
    end else if (cmd_i.emit_rd) begin
      rd_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (cmd_i.load) begin
      value_q <= value_i;
      last_q  <= last_i;
    end
  end

  always_comb begin
    fill_d    = fill_q;
    dropped_d = dropped_q;
    pos_d     = pos_q;
    k_d       = k_q;
    if (cmd_i.place_direct || cmd_i.place) begin
      fill_d = fill_q + CW'(1);
    end
    if (cmd_i.drop) begin
      dropped_d = 1'b1;
    end
    if (cmd_i.start_search) begin
      pos_d = fill_idx;
    end
    if (cmd_i.shift) begin
      pos_d = pos_q - AW'(1);
    end
    if (cmd_i.emit_rd) begin
      k_d = k_q + AW'(1);
    end
    if (cmd_i.clear) begin
      fill_d    = '0;
      dropped_d = 1'b0;
      k_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      dropped_q  <= 1'b0;
      pos_q      <= '0;
      k_q        <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      dropped_q  <= dropped_d;
      pos_q      <= pos_d;
      k_q        <= k_d;
      out_v_q    <= cmd_i.emit_rd;
      out_last_q <= cmd_i.emit_rd & stat_o.k_last;
      out_ovf_q  <= cmd_i.emit_rd & dropped_q;
    end
  end

  always_comb begin
    stat_o.full      = (fill_q == CW'(MAX_ITEMS));
    stat_o.fill_zero = (fill_q == '0);
    stat_o.greater   = ($signed(rdata_q) > value_q);
    stat_o.pos_one   = (pos_q == AW'(1));
    stat_o.k_last    = ((CW'(k_q) + CW'(1)) == fill_q);
    stat_o.last      = last_q;
  end

  assign value_res_o  = $signed(rdata_q);
  assign last_res_o   = out_last_q;
  assign overflow_o   = out_ovf_q;
  assign res_strobe_o = out_v_q;

endmodule

`default_nettype wire

>>> src/isrt_ctrl.sv
// Controller of the insertion sorter: sequences search, placement and output.
// Talks to isrt_datapath through the isrt_pkg command and status structs.
`default_nettype none

module isrt_ctrl import isrt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic       last_i,
  output logic            busy,
  input  wire isrt_stat_t stat_i,
  output isrt_cmd_t       cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StPlace  = 2'd2;
  localparam logic [1:0] StEmit   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          priority if (stat_i.full) begin
            cmd_o.drop = 1'b1;
            if (last_i) state_d = StEmit;
          end else if (stat_i.fill_zero) begin
            cmd_o.place_direct = 1'b1;
            if (last_i) state_d = StEmit;
          end else begin
            cmd_o.start_search = 1'b1;
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        if (stat_i.greater) begin
          cmd_o.shift = 1'b1;
          if (stat_i.pos_one) state_d = StPlace;
        end else begin
          cmd_o.place = 1'b1;
          state_d = stat_i.last ? StEmit : StIdle;
        end
      end
      StPlace: begin
        cmd_o.place = 1'b1;
        state_d = stat_i.last ? StEmit : StIdle;
      end
      StEmit: begin
        cmd_o.emit_rd = 1'b1;
        if (stat_i.k_last) begin
          cmd_o.clear = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

`default_nettype wire

>>> src/insertion_sorter_core.sv
// Top level of the insertion sorter: controller plus datapath.
// Depends on isrt_pkg, isrt_ctrl and isrt_datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  input    | start && !busy         | value_i, last_i
//  result   | res_strobe_o           | value_res_o, last_res_o, overflow_o
//
// An item with an empty or full store is taken while idle. Otherwise a search
// shifts each stored entry greater than the value up one slot, then places the
// value; the store has one read and one write port, one compare-and-shift a cycle.
// A last item then streams out the results, one per stored entry.
// Reset clears counts and the overflow and result flags; store contents are
// undefined until written. Results cannot be stalled; they appear back to back, one per cycle.
`default_nettype none

module insertion_sorter_core import isrt_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     last_i,
  output logic                          res_strobe_o,
  output logic signed [DATA_W-1:0]      value_res_o,
  output logic                          last_res_o,
  output logic                          overflow_o
);

  isrt_cmd_t  cmd;
  isrt_stat_t stat;

  isrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .last_i (last_i),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  isrt_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (value_i),
    .last_i       (last_i),
    .value_res_o  (value_res_o),
    .last_res_o   (last_res_o),
    .overflow_o   (overflow_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule

`default_nettype wire

>>> src/isrt_checker.sv
// Port-level checks for insertion_sorter_core, attached with bind.
// Depends on isrt_pkg for the data width.
`default_nettype none

module isrt_checker import isrt_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              res_strobe_o,
  input wire logic              last_res_o,
  input wire logic              overflow_o,
  input wire logic [DATA_W-1:0] value_res_o
);

  // A run streams without gaps.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_res_o |=> res_strobe_o)
    else $error("gap inside a result run");

  // Nothing follows the final result directly.
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_res_o |=> !res_strobe_o)
    else $error("result directly after final result");

  // Overflow flag is constant across one run.
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_res_o |=> overflow_o == $past(overflow_o))
    else $error("overflow flag changed within a run");

  // Accepting a transaction never produces a result in the next cycle.
  a_no_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !res_strobe_o)
    else $error("result right after an accepted transaction");

  // Only written store entries are streamed out.
  a_value_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !$isunknown(value_res_o))
    else $error("unknown value on a result");

endmodule

bind insertion_sorter_core isrt_checker u_isrt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .last_res_o   (last_res_o),
  .overflow_o   (overflow_o),
  .value_res_o  (value_res_o)
);

`default_nettype wire

>>> sim/tb_insertion_sorter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for insertion_sorter_core: runs of signed values
// with random gaps, checked against an in-bench stable insertion sort.
// Depends on isrt_pkg and the insertion_sorter_core RTL.

module tb_insertion_sorter_core;
  import isrt_pkg::*;

  localparam int unsigned SORT_DEPTH = 16;
  localparam int unsigned ITEM_GOAL  = 330;
  localparam int unsigned MAX_GAP    = 18;
  localparam int unsigned MAX_MSGS   = 100;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    word_t value;
    logic  last;
    int    gap;    // idle cycles before this item is offered
  } feed_item_t;

  typedef struct {
    word_t value;
    logic  last;
    logic  overflow;
  } sorted_word_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  word_t value_i = '0;
  logic  last_i = 1'b0;
  logic  busy;
  logic  res_strobe_o;
  word_t value_res_o;
  logic  last_res_o;
  logic  overflow_o;

  insertion_sorter_core #(
    .MAX_ITEMS(SORT_DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .last_i      (last_i),
    .res_strobe_o(res_strobe_o),
    .value_res_o (value_res_o),
    .last_res_o  (last_res_o),
    .overflow_o  (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  feed_item_t   value_feed[$];
  sorted_word_t sorted_out_q[$];

  // Shadow of the sorted store.
  word_t shadow_store[SORT_DEPTH];
  int    shadow_fill = 0;
  bit    shadow_dropped = 1'b0;

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned mismatch_cnt = 0;
  int          wait_left = 0;
  bit          feed_idle = 1'b0;

  // Stable insertion: land after every entry <= v; flush the run on last.
  function automatic void insert_value(word_t v, logic is_last);
    int           pos;
    sorted_word_t r;
    if (shadow_fill < SORT_DEPTH) begin
      pos = shadow_fill;
      while (pos > 0 && shadow_store[pos-1] > v) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = v;
      shadow_fill++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (is_last) begin
      for (int k = 0; k < shadow_fill; k++) begin
        r.value    = shadow_store[k];
        r.last     = (k == shadow_fill - 1);
        r.overflow = shadow_dropped;
        sorted_out_q.push_back(r);
      end
      shadow_fill    = 0;
      shadow_dropped = 1'b0;
    end
  endfunction

  function automatic void queue_value(word_t v, logic is_last);
    feed_item_t it;
    if ($urandom_range(0, 15) == 0)
      feed_idle = ~feed_idle;
    it.value = v;
    it.last  = is_last;
    it.gap   = feed_idle ? $urandom_range(0, MAX_GAP) : 0;
    value_feed.push_back(it);
    items_queued++;
  endfunction

  function automatic word_t edge_value();
    case ($urandom_range(0, 6))
      0:       return WORD_MIN;
      1:       return WORD_MIN + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return WORD_MAX - 1;
      default: return WORD_MAX;
    endcase
  endfunction

  function automatic void report_field(string name, longint want, longint got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_MSGS)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
  endfunction

  // Driver: offers the next item once the gap has run out; start stays high
  // across back-to-back transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        insert_value(value_i, last_i);
        items_taken <= items_taken + 1;
      end
      if (!start || !busy) begin
        if (value_feed.size() != 0 && wait_left == 0) begin
          value_i <= value_feed[0].value;
          last_i  <= value_feed[0].last;
          start   <= 1'b1;
          void'(value_feed.pop_front());
          if (value_feed.size() != 0)
            wait_left = value_feed[0].gap;
        end else begin
          start <= 1'b0;
          if (wait_left > 0)
            wait_left--;
        end
      end
    end
  end

  // Monitor: results cannot be stalled, so every strobe is a transaction.
  always @(posedge clk_i) begin
    sorted_word_t want;
    if (rst_ni && res_strobe_o) begin
      if (sorted_out_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_MSGS)
          $display("%0t: unexpected result: expected none, actual value %0d last %0b",
                   $time, value_res_o, last_res_o);
      end else begin
        want = sorted_out_q.pop_front();
        if (value_res_o !== want.value)
          report_field("value_res", want.value, value_res_o);
        if (last_res_o !== want.last)
          report_field("last_res", want.last, last_res_o);
        if (overflow_o !== want.overflow)
          report_field("overflow", want.overflow, overflow_o);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int    run_len;
    int    mode;
    word_t walk;
    word_t v;

    // Directed: extremes and duplicates in one run, a single-item run,
    // then a run that fills the store and drops the last item too.
    queue_value(WORD_MAX, 1'b0);
    queue_value(WORD_MIN, 1'b0);
    queue_value(0, 1'b0);
    queue_value(-1, 1'b0);
    queue_value(1, 1'b0);
    queue_value(WORD_MIN, 1'b0);
    queue_value(WORD_MAX, 1'b1);
    queue_value(-7, 1'b1);
    for (int i = 0; i < SORT_DEPTH + 1; i++)
      queue_value(word_t'(SORT_DEPTH - i) - 3, i == SORT_DEPTH);

    // Random runs: mostly within capacity, some past it.
    while (items_queued < ITEM_GOAL) begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 5)
                                            : $urandom_range(1, SORT_DEPTH);
      mode = $urandom_range(0, 5);
      walk = $urandom;
      for (int i = 0; i < run_len; i++) begin
        case (mode)
          1:       v = word_t'($urandom_range(0, 8)) - 4;
          2:       v = edge_value();
          3: begin
            walk = walk - word_t'($urandom_range(0, 3000));
            v    = walk;
          end
          4: begin
            walk = walk + word_t'($urandom_range(0, 3000));
            v    = walk;
          end
          default: v = $urandom;
        endcase
        queue_value(v, i == run_len - 1);
      end
    end

    wait_left = value_feed[0].gap;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken != items_queued || sorted_out_q.size() != 0)
      @(negedge clk_i);
    repeat (2 * SORT_DEPTH + 8) @(negedge clk_i);

    if (mismatch_cnt == 0 && sorted_out_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
